>>> rtl/sqv_pkg.sv
// Shared types and constants for the square voice with ADSR envelope.
// Holds the microcode word layout, the control store and the register map.
// No dependencies.
package sqv_pkg;

    // Configuration register map.
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VELOCITY = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] ATTACK_RESET   = 16'd480;
    localparam logic [15:0] DECAY_RESET    = 16'd1440;
    localparam logic [15:0] RELEASE_RESET  = 16'd2400;
    localparam logic [31:0] STEP_RESET     = 32'd39370534;
    localparam logic [15:0] VELOCITY_RESET = 16'd32768;

    // Envelope levels in Q1.15.
    localparam logic [15:0] AMP_ONE     = 16'd32768;
    localparam logic [15:0] AMP_SUSTAIN = 16'd16384;

    localparam logic [23:0] MIX_MAX = 24'h7FFFFF;
    localparam logic [23:0] MIX_MIN = 24'h800000;

    // Quotient bits produced by the restoring divider.
    localparam logic [3:0] DIV_STEPS = 4'd15;

    typedef enum logic [2:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_RELEASE,
        SEG_SUSTAIN,
        SEG_SILENT
    } seg_t;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_SELECT,
        OP_DIV,
        OP_AMP,
        OP_MUL,
        OP_MIX
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef logic [2:0] pc_t;

    localparam pc_t STEP_ACCEPT = 3'd0;
    localparam pc_t STEP_SELECT = 3'd1;
    localparam pc_t STEP_DIV    = 3'd2;
    localparam pc_t STEP_AMP    = 3'd3;
    localparam pc_t STEP_MUL    = 3'd4;
    localparam pc_t STEP_MIX    = 3'd5;

    // One control word: the datapath operation, a condition that holds the
    // step counter where it is, and a condition that jumps to the target.
    typedef struct packed {
        op_t   op;
        cond_t hold_on;
        cond_t jump_on;
        pc_t   target;
    } ucode_t;

    function automatic ucode_t ucode_fetch(input pc_t pc);
        ucode_t w;
        unique case (pc)
            STEP_ACCEPT: w = '{op: OP_ACCEPT, hold_on: C_NO_ITEM, jump_on: C_NEVER,
                               target: STEP_ACCEPT};
            STEP_SELECT: w = '{op: OP_SELECT, hold_on: C_NEVER, jump_on: C_NEVER,
                               target: STEP_ACCEPT};
            STEP_DIV:    w = '{op: OP_DIV, hold_on: C_NEVER, jump_on: C_DIV_MORE,
                               target: STEP_DIV};
            STEP_AMP:    w = '{op: OP_AMP, hold_on: C_NEVER, jump_on: C_NEVER,
                               target: STEP_ACCEPT};
            STEP_MUL:    w = '{op: OP_MUL, hold_on: C_NEVER, jump_on: C_NEVER,
                               target: STEP_ACCEPT};
            STEP_MIX:    w = '{op: OP_MIX, hold_on: C_OUT_BUSY, jump_on: C_ALWAYS,
                               target: STEP_ACCEPT};
            default:     w = '{op: OP_ACCEPT, hold_on: C_NEVER, jump_on: C_ALWAYS,
                               target: STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/square_voice_with_adsr_envelope_unit.sv
// One square-wave synth voice with a linear ADSR envelope, mixed into a stream.
// Depends on sqv_pkg for the control store, register map and constants.
//
// A mix request runs through one accept step, one envelope segment selection,
// fifteen steps of the shared restoring divider that forms the envelope slope,
// then the amplitude, velocity multiply and mix steps, all run from a six-word
// control store; the next request is taken once the mix step is done. The mix
// step waits while the previous result is still held on the output. A note-off
// request is taken at the accept step, which it does not leave, and gives no result.
// Configuration writes are taken in any cycle; write them only while idle.
module square_voice_with_adsr_envelope_unit
    import sqv_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic signed [23:0]        s_mix_in,
    input  logic                      s_last_channel,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [23:0]        m_mixed_out,
    output logic                      m_exhausted
);

    localparam int unsigned CW1 = COUNT_BITS + 1;
    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    // Configuration.
    logic [15:0] attack_reg, decay_reg, release_reg, velocity_reg;
    logic [31:0] step_reg;

    // Voice state.
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  released_reg, released_next;
    logic [COUNT_BITS-1:0] rel_start_reg, rel_start_next;

    // Sequencer.
    pc_t    pc_reg, pc_next;
    ucode_t uw;
    logic   hold, jump;

    // Datapath.
    logic [23:0] mix_reg, mix_next;
    logic        last_reg, last_next;
    seg_t        seg_reg, seg_next;
    logic        exh_reg, exh_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [14:0] quo_reg, quo_next;
    logic [3:0]  divc_reg, divc_next;
    logic [15:0] amp_reg, amp_next;
    logic [16:0] mag_reg, mag_next;

    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_mixed_reg, m_mixed_next;
    logic        m_exh_reg, m_exh_next;

    logic                  out_free;
    logic                  accept;
    logic [16:0]           ad_sum;
    logic [COUNT_BITS-1:0] rel_gap;
    logic                  in_attack, in_decay, rel_over;
    logic [16:0]           rem_dbl;
    logic                  rem_ge;
    logic [31:0]           prod;
    logic [24:0]           voice, sum;

    function automatic logic cond_eval(
        input cond_t c,
        input logic  no_item,
        input logic  div_more,
        input logic  out_busy
    );
        logic r;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_NO_ITEM:  r = no_item;
            C_DIV_MORE: r = div_more;
            C_OUT_BUSY: r = out_busy;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    assign uw        = ucode_fetch(pc_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (uw.op == OP_ACCEPT);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid     = m_valid_reg;
    assign m_mixed_out = m_mixed_reg;
    assign m_exhausted = m_exh_reg;

    // Step counter.
    always_comb begin
        hold = cond_eval(uw.hold_on, !(s_valid && !s_action), divc_reg != 4'd1, !out_free);
        jump = cond_eval(uw.jump_on, !(s_valid && !s_action), divc_reg != 4'd1, !out_free);
        if (hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 3'd1;
        end
    end

    // Datapath, driven by the current control word.
    always_comb begin
        count_next     = count_reg;
        phase_next     = phase_reg;
        released_next  = released_reg;
        rel_start_next = rel_start_reg;
        mix_next       = mix_reg;
        last_next      = last_reg;
        seg_next       = seg_reg;
        exh_next       = exh_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        divc_next      = divc_reg;
        amp_next       = amp_reg;
        mag_next       = mag_reg;
        m_mixed_next   = m_mixed_reg;
        m_exh_next     = m_exh_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        ad_sum    = {1'b0, attack_reg} + {1'b0, decay_reg};
        rel_gap   = count_reg - rel_start_reg;
        in_attack = count_reg < COUNT_BITS'(attack_reg);
        in_decay  = count_reg < COUNT_BITS'(ad_sum);
        rel_over  = (release_reg == 16'd0) || (rel_gap >= COUNT_BITS'(release_reg));
        rem_dbl   = {rem_reg, 1'b0};
        rem_ge    = rem_dbl >= {1'b0, den_reg};
        prod      = amp_reg * velocity_reg;
        voice     = (phase_reg > PHASE_HALF) ? {8'd0, mag_reg} : (25'd0 - {8'd0, mag_reg});
        sum       = {mix_reg[23], mix_reg} + voice;

        unique case (uw.op)
            OP_ACCEPT: begin
                if (accept) begin
                    if (s_action) begin
                        rel_start_next = count_reg;
                        released_next  = 1'b1;
                    end else begin
                        mix_next  = s_mix_in;
                        last_next = s_last_channel;
                    end
                end
            end
            OP_SELECT: begin
                // Each slope is a remainder below its length, so the divider
                // only needs the fractional quotient bits.
                divc_next = DIV_STEPS;
                quo_next  = '0;
                exh_next  = released_reg &&
                            ({1'b0, count_reg} >= ({1'b0, rel_start_reg} + CW1'(release_reg)));
                if (in_attack) begin
                    seg_next = SEG_ATTACK;
                    rem_next = count_reg[15:0];
                    den_next = attack_reg;
                end else if (in_decay) begin
                    seg_next = SEG_DECAY;
                    rem_next = 16'(count_reg - COUNT_BITS'(attack_reg));
                    den_next = decay_reg;
                end else if (released_reg && !rel_over) begin
                    seg_next = SEG_RELEASE;
                    rem_next = rel_gap[15:0];
                    den_next = release_reg;
                end else begin
                    seg_next = released_reg ? SEG_SILENT : SEG_SUSTAIN;
                    rem_next = '0;
                    den_next = 16'd1;
                end
            end
            OP_DIV: begin
                rem_next  = rem_ge ? 16'(rem_dbl - {1'b0, den_reg}) : rem_dbl[15:0];
                quo_next  = {quo_reg[13:0], rem_ge};
                divc_next = divc_reg - 4'd1;
            end
            OP_AMP: begin
                // Decay and release slopes span half of full scale, so they
                // use the quotient halved.
                case (seg_reg)
                    SEG_ATTACK:  amp_next = {1'b0, quo_reg};
                    SEG_DECAY:   amp_next = AMP_ONE - {2'b00, quo_reg[14:1]};
                    SEG_RELEASE: amp_next = AMP_SUSTAIN - {2'b00, quo_reg[14:1]};
                    SEG_SUSTAIN: amp_next = AMP_SUSTAIN;
                    default:     amp_next = '0;
                endcase
            end
            OP_MUL: begin
                mag_next = prod[31:15];
            end
            OP_MIX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_exh_next   = exh_reg;
                    if (sum[24] != sum[23]) begin
                        m_mixed_next = sum[24] ? MIX_MIN : MIX_MAX;
                    end else begin
                        m_mixed_next = sum[23:0];
                    end
                    if (last_reg) begin
                        phase_next = phase_reg + PHASE_BITS'(step_reg);
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= STEP_ACCEPT;
            m_valid_reg   <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= '0;
            released_reg  <= 1'b0;
            rel_start_reg <= '0;
            attack_reg    <= ATTACK_RESET;
            decay_reg     <= DECAY_RESET;
            release_reg   <= RELEASE_RESET;
            step_reg      <= STEP_RESET;
            velocity_reg  <= VELOCITY_RESET;
        end else begin
            pc_reg        <= pc_next;
            m_valid_reg   <= m_valid_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            released_reg  <= released_next;
            rel_start_reg <= rel_start_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ATTACK:   attack_reg   <= cfg_data[15:0];
                    REG_DECAY:    decay_reg    <= cfg_data[15:0];
                    REG_RELEASE:  release_reg  <= cfg_data[15:0];
                    REG_STEP:     step_reg     <= cfg_data;
                    REG_VELOCITY: velocity_reg <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mix_reg     <= mix_next;
        last_reg    <= last_next;
        seg_reg     <= seg_next;
        exh_reg     <= exh_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        divc_reg    <= divc_next;
        amp_reg     <= amp_next;
        mag_reg     <= mag_next;
        m_mixed_reg <= m_mixed_next;
        m_exh_reg   <= m_exh_next;
    end

endmodule
